### hw/rtl/mwcs_pkg.sv
package mwcs_pkg;

  localparam int CHAR_W   = 7;
  localparam int ALPHABET = 128;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;

  localparam logic [1:0] KIND_CLEAR   = 2'd0;
  localparam logic [1:0] KIND_PATTERN = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [ALPHABET-1:0] char_mask_t;

endpackage

### hw/rtl/mwcs_ram.sv
module mwcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/min_window_cover_search.sv
// Shortest covering window search. A clear item (kind 0) empties the pattern,
// the text and the best window and clears overflow. Pattern items (kind 1)
// add to the required-character histogram. Text items (kind 2) are stored
// and counted, then the left edge is advanced while the window still holds
// every pattern character; each text item answers with the best window so far.
// A text item reads the counts of its character, then each left-edge step
// reads the leaving character from the text store and then its counts; every
// character leaves the window at most once. The text store and the two
// histogram RAMs have registered reads, and each count is read and written
// back in turn. Text past MAX_TEXT characters is dropped, raises overflow and
// still answers. Histograms clear at once through per-entry valid bits,
// so there is no clearing pass after reset. A finished result waits in the
// output register while the next item is accepted.
module min_window_cover_search
  import mwcs_pkg::*;
#(
  parameter int MAX_TEXT    = 4096,
  parameter int MAX_PATTERN = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [CHAR_W-1:0]  char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [START_W-1:0] best_start,
  output logic [LEN_W-1:0]   best_len,
  output logic               overflow
);

  localparam int PW  = $clog2(MAX_TEXT + 1);
  localparam int PCW = $clog2(MAX_PATTERN + 1);
  localparam int CW  = (PW > PCW) ? PW : PCW;
  localparam int AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

  localparam logic [PW-1:0] TEXT_MAX = PW'(MAX_TEXT);
  localparam logic [CW-1:0] PAT_MAX  = CW'(MAX_PATTERN);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [PW-1:0] POS_ONE  = PW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_C  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD_T  = 3'd3;
  localparam logic [2:0] S_RD_L  = 3'd4;
  localparam logic [2:0] S_RD_P  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]    state;
  logic [2:0]    state_next;
  char_mask_t    pat_valid;
  char_mask_t    win_valid;
  char_t         cur_char;
  logic [PW-1:0] cur_pos;
  logic [PW-1:0] left_edge;
  logic [PW-1:0] next_position;
  logic [7:0]    kinds_needed;
  logic [7:0]    kinds_met;
  logic [PW-1:0] shortest_len;
  logic [PW-1:0] shortest_start;
  logic          any_found;
  logic          overflowed;

  logic          accept;
  logic          out_free;
  logic          text_full;
  logic          shrink;
  logic [PW-1:0] win_len;
  logic [31:0]   start_ext;
  logic [31:0]   len_ext;

  char_t         hist_raddr;
  logic [CW-1:0] pat_rdata;
  logic [CW-1:0] win_rdata;
  logic [CW-1:0] pat_cnt;
  logic [CW-1:0] win_cnt;
  logic          pat_we;
  logic          win_we;
  logic [CW-1:0] pat_wdata;
  logic [CW-1:0] win_wdata;
  logic          text_we;
  logic [AW-1:0] text_waddr;
  logic [AW-1:0] text_raddr;
  logic [CHAR_W-1:0] text_rdata;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign text_full = (next_position >= TEXT_MAX);
  assign shrink    = (left_edge <= cur_pos) && (kinds_met == kinds_needed);
  assign win_len   = cur_pos - left_edge + POS_ONE;

  // entries not written since the last clear read as zero
  assign pat_cnt = pat_valid[cur_char] ? pat_rdata : '0;
  assign win_cnt = win_valid[cur_char] ? win_rdata : '0;

  assign hist_raddr = (state == S_RD_T) ? char_t'(text_rdata) : char_code;

  assign text_we    = accept && (kind == KIND_TEXT) && !text_full;
  assign text_waddr = next_position[AW-1:0];
  assign text_raddr = left_edge[AW-1:0];

  assign pat_we    = (state == S_RD_P) && (pat_cnt < PAT_MAX);
  assign pat_wdata = pat_cnt + CNT_ONE;
  assign win_we    = (state == S_RD_C) || (state == S_RD_L);
  assign win_wdata = (state == S_RD_C) ? win_cnt + CNT_ONE : win_cnt - CNT_ONE;

  mwcs_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (cur_char),
    .wdata (pat_wdata),
    .raddr (hist_raddr),
    .rdata (pat_rdata)
  );

  mwcs_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (cur_char),
    .wdata (win_wdata),
    .raddr (hist_raddr),
    .rdata (win_rdata)
  );

  mwcs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_TEXT)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (char_code),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_PATTERN) begin
            state_next = S_RD_P;
          end else if (kind == KIND_TEXT) begin
            state_next = text_full ? S_EMIT : S_RD_C;
          end
        end
      end
      S_RD_C:  state_next = S_CHECK;
      S_CHECK: state_next = shrink ? S_RD_T : S_EMIT;
      S_RD_T:  state_next = S_RD_L;
      S_RD_L:  state_next = S_CHECK;
      S_RD_P:  state_next = S_IDLE;
      S_EMIT:  state_next = out_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  assign start_ext = 32'(shortest_start);
  assign len_ext   = 32'(shortest_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      pat_valid      <= '0;
      win_valid      <= '0;
      left_edge      <= '0;
      next_position  <= '0;
      cur_pos        <= '0;
      kinds_needed   <= '0;
      kinds_met      <= '0;
      shortest_len   <= '0;
      shortest_start <= '0;
      any_found      <= 1'b0;
      overflowed     <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          cur_char <= char_code;
          cur_pos  <= next_position;
          if (accept && kind == KIND_CLEAR) begin
            pat_valid      <= '0;
            win_valid      <= '0;
            left_edge      <= '0;
            next_position  <= '0;
            kinds_needed   <= '0;
            kinds_met      <= '0;
            shortest_len   <= '0;
            shortest_start <= '0;
            any_found      <= 1'b0;
            overflowed     <= 1'b0;
          end else if (accept && kind == KIND_TEXT && text_full) begin
            overflowed <= 1'b1;
          end
        end
        S_RD_C: begin
          win_valid[cur_char] <= 1'b1;
          next_position       <= cur_pos + POS_ONE;
          if (pat_cnt != '0 && win_cnt + CNT_ONE == pat_cnt) begin
            kinds_met <= kinds_met + 8'd1;
          end
        end
        S_CHECK: begin
          if (shrink && (!any_found || win_len < shortest_len)) begin
            any_found      <= 1'b1;
            shortest_len   <= win_len;
            shortest_start <= left_edge;
          end
        end
        S_RD_T: begin
          cur_char <= char_t'(text_rdata);
        end
        S_RD_L: begin
          left_edge <= left_edge + POS_ONE;
          if (pat_cnt != '0 && win_cnt - CNT_ONE < pat_cnt) begin
            kinds_met <= kinds_met - 8'd1;
          end
        end
        S_RD_P: begin
          if (pat_we) begin
            pat_valid[cur_char] <= 1'b1;
            if (pat_cnt == '0) begin
              kinds_needed <= kinds_needed + 8'd1;
            end
            // the character was met and the window now falls one short
            if (pat_cnt != '0 && win_cnt == pat_cnt) begin
              kinds_met <= kinds_met - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      found      <= any_found;
      best_start <= any_found ? start_ext[START_W-1:0] : '0;
      best_len   <= any_found ? len_ext[LEN_W-1:0] : '0;
      overflow   <= overflowed;
    end
  end

  a_left_behind: assert property (@(posedge clk) disable iff (rst)
    left_edge <= next_position)
    else $error("left edge passed the write position");

  a_found_len: assert property (@(posedge clk) disable iff (rst)
    any_found |-> shortest_len != '0)
    else $error("recorded window has zero length");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflowed && !(accept && kind == KIND_CLEAR) |=> overflowed)
    else $error("overflow dropped without a clear");

endmodule

### bench/tb_min_window_cover_search.sv
`timescale 1ns / 100ps

module tb_min_window_cover_search
  import mwcs_pkg::*;
();

  localparam int TEXT_DEPTH    = 4096;
  localparam int PATTERN_LIMIT = 4096;
  localparam int CYCLE_LIMIT   = 900_000;
  localparam int STALL_CYCLES  = 400;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    char_t      code;
  } job_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] win_start;
    logic [LEN_W-1:0]   win_len;
    logic               ovf;
  } best_window_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = KIND_CLEAR;
  char_t              char_code = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [START_W-1:0] best_start;
  logic [LEN_W-1:0]   best_len;
  logic               overflow;

  job_t         job_q[$];
  best_window_t best_window_q[$];

  int send_idle_pct = 9;
  int recv_idle_pct = 82;
  int err_cnt = 0;
  int n_accepted = 0;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;

  // predictor state
  logic [LEN_W-1:0]   pat_cnt[ALPHABET];
  logic [LEN_W-1:0]   win_cnt[ALPHABET];
  char_t              text_mem[TEXT_DEPTH];
  logic [LEN_W-1:0]   left_edge;
  logic [LEN_W-1:0]   next_pos;
  logic [7:0]         kinds_needed;
  logic [7:0]         kinds_met;
  logic [LEN_W-1:0]   best_len_r;
  logic [START_W-1:0] best_start_r;
  logic               any_found;
  logic               ovf_seen;

  min_window_cover_search i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .char_code  (char_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .best_start (best_start),
    .best_len   (best_len),
    .overflow   (overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_search_state();
    for (int i = 0; i < ALPHABET; i++) begin
      pat_cnt[i] = '0;
      win_cnt[i] = '0;
    end
    left_edge    = '0;
    next_pos     = '0;
    kinds_needed = '0;
    kinds_met    = '0;
    best_len_r   = '0;
    best_start_r = '0;
    any_found    = 1'b0;
    ovf_seen     = 1'b0;
  endfunction

  // Returns 1 when the item produces a result, placed in r.
  function automatic bit window_search_step(input logic [1:0] k, input char_t c,
                                            output best_window_t r);
    logic [LEN_W-1:0] old_cnt;
    logic [LEN_W-1:0] span;
    logic [LEN_W-1:0] pos;
    char_t            lc;
    bit               met_before;
    r = '0;
    case (k)
      KIND_CLEAR: begin
        clear_search_state();
        return 1'b0;
      end
      KIND_PATTERN: begin
        old_cnt = pat_cnt[c];
        if (old_cnt < PATTERN_LIMIT) begin
          met_before = (old_cnt != 0) && (win_cnt[c] >= old_cnt);
          pat_cnt[c] = old_cnt + 1'b1;
          if (old_cnt == 0) kinds_needed = kinds_needed + 1'b1;
          if (met_before && win_cnt[c] < pat_cnt[c]) kinds_met = kinds_met - 1'b1;
        end
        return 1'b0;
      end
      KIND_TEXT: begin
        if (next_pos >= TEXT_DEPTH) begin
          ovf_seen = 1'b1;
        end else begin
          pos = next_pos;
          text_mem[pos[START_W-1:0]] = c;
          win_cnt[c] = win_cnt[c] + 1'b1;
          if (pat_cnt[c] != 0 && win_cnt[c] == pat_cnt[c]) kinds_met = kinds_met + 1'b1;
          next_pos = pos + 1'b1;
          // shrink from the left while the window still covers
          while (left_edge <= pos && kinds_met == kinds_needed) begin
            span = pos - left_edge + 1'b1;
            lc   = text_mem[left_edge[START_W-1:0]];
            if (!any_found || span < best_len_r) begin
              any_found    = 1'b1;
              best_len_r   = span;
              best_start_r = left_edge[START_W-1:0];
            end
            win_cnt[lc] = win_cnt[lc] - 1'b1;
            if (pat_cnt[lc] != 0 && win_cnt[lc] < pat_cnt[lc]) kinds_met = kinds_met - 1'b1;
            left_edge = left_edge + 1'b1;
          end
        end
        r.found     = any_found;
        r.win_start = any_found ? best_start_r : '0;
        r.win_len   = any_found ? best_len_r : '0;
        r.ovf       = ovf_seen;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    job_t         nxt;
    best_window_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (window_search_step(kind, char_code, r)) best_window_q.push_back(r);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (job_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = job_q.pop_front();
          in_valid  <= 1'b1;
          kind      <= nxt.kind;
          char_code <= nxt.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the output backs up into the input
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (!stall_done && n_accepted >= 60) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    best_window_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (best_window_q.size() == 0) begin
          $error("result with no pending expectation");
          err_cnt++;
        end else begin
          exp_r = best_window_q.pop_front();
          if (found !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, found);
            err_cnt++;
          end
          if (best_start !== exp_r.win_start) begin
            $error("best_start: expected %0d, got %0d", exp_r.win_start, best_start);
            err_cnt++;
          end
          if (best_len !== exp_r.win_len) begin
            $error("best_len: expected %0d, got %0d", exp_r.win_len, best_len);
            err_cnt++;
          end
          if (overflow !== exp_r.ovf) begin
            $error("overflow: expected %0d, got %0d", exp_r.ovf, overflow);
            err_cnt++;
          end
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_job(input logic [1:0] k, input char_t c);
    job_t j;
    j.kind = k;
    j.code = c;
    job_q.push_back(j);
  endtask

  // Random jobs: mostly clear, short pattern, then text drawn from a small
  // alphabet so that covers are common; some noise mixed in.
  task automatic add_search_jobs(input int target);
    int    added;
    int    plen;
    int    tlen;
    int    roll;
    char_t alpha[4];
    added = 0;
    while (added < target) begin
      for (int i = 0; i < 4; i++) alpha[i] = char_t'($urandom_range(127));
      if ($urandom_range(99) < 85) begin
        add_job(KIND_CLEAR, char_t'($urandom_range(127)));
        added++;
      end
      plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      for (int i = 0; i < plen; i++) begin
        add_job(KIND_PATTERN, alpha[$urandom_range(2)]);
        added++;
      end
      tlen = $urandom_range(3, 30);
      for (int i = 0; i < tlen; i++) begin
        roll = $urandom_range(99);
        if (roll < 86) begin
          add_job(KIND_TEXT, alpha[$urandom_range(3)]);
          added++;
        end else if (roll < 93) begin
          add_job(KIND_TEXT, char_t'($urandom_range(127)));
          added++;
        end else if (roll < 98) begin
          add_job(KIND_PATTERN, alpha[$urandom_range(3)]);
          added++;
        end else begin
          add_job(KIND_UNUSED, char_t'($urandom_range(127)));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (job_q.size() != 0 || in_valid || best_window_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    clear_search_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender idles little, receiver idles a lot
    send_idle_pct = 9;
    recv_idle_pct = 82;
    // empty pattern: every text item covers by itself
    add_job(KIND_TEXT, 7'h61);
    add_job(KIND_TEXT, 7'h7F);
    add_job(KIND_TEXT, 7'h00);
    add_job(KIND_CLEAR, 7'h7F);
    // repeated pattern character needs its multiplicity
    add_job(KIND_PATTERN, 7'h61);
    add_job(KIND_PATTERN, 7'h62);
    add_job(KIND_PATTERN, 7'h61);
    add_job(KIND_TEXT, 7'h62);
    add_job(KIND_TEXT, 7'h61);
    add_job(KIND_TEXT, 7'h63);
    add_job(KIND_TEXT, 7'h61);
    add_job(KIND_TEXT, 7'h62);
    // pattern grows after text has arrived
    add_job(KIND_PATTERN, 7'h63);
    add_job(KIND_TEXT, 7'h63);
    add_job(KIND_UNUSED, 7'h55);
    add_job(KIND_UNUSED, 7'h2A);
    add_job(KIND_TEXT, 7'h61);
    add_job(KIND_CLEAR, 7'h00);
    add_job(KIND_TEXT, 7'h40);
    add_job(KIND_PATTERN, 7'h7F);
    add_job(KIND_TEXT, 7'h00);
    add_job(KIND_TEXT, 7'h7F);
    add_search_jobs(220);
    wait_drained();

    // sender idles a lot, receiver idles little
    send_idle_pct = 82;
    recv_idle_pct = 9;
    add_search_jobs(220);
    wait_drained();

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_search_jobs(60);
    wait_drained();

    repeat (40) @(negedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
